FILE: sv/spfc_pkg.sv
package spfc_pkg;

  // position fixed point: 8 fraction bits, 22 bits wide
  localparam int unsigned PosFracBits = 8;
  localparam int unsigned PosW        = 22;
  localparam logic [PosW-1:0] PosReset = 22'd204800;   // 800.0
  localparam logic [PosW-1:0] PosMax   = 22'd2560000;  // 10000.0

  localparam logic [13:0] TestSpeed = 14'd600;

  // loop arithmetic widths
  localparam int unsigned ProdW  = 31;  // speed * ref
  localparam int unsigned Flow100W = 23;  // 100 * flow
  localparam int unsigned ScaledW = 45;  // err * rate
  localparam int unsigned MagW   = 44;
  localparam int unsigned DeltaW = 37;

  // divide by 625 (16 / 10000): 16-bit quotient digits by reciprocal multiply,
  // each digit a multiply, then a remainder step
  localparam logic [9:0]  DivConst   = 10'd625;
  localparam int unsigned DivW       = 48;
  localparam int unsigned DivChunkW  = 16;
  localparam int unsigned RemW       = 10;
  localparam int unsigned DivVW      = RemW + DivChunkW;
  localparam int unsigned RecipW     = 27;
  localparam logic [RecipW-1:0] RecipConst = 27'd109951163;  // ceil(2^36 / 625)
  localparam int unsigned RecipShift = 36;
  localparam int unsigned RecipProdW = DivVW + RecipW;
  localparam int unsigned DivIters   = 2 * (DivW / DivChunkW);
  localparam int unsigned DivCntW    = 3;
  localparam int unsigned QuotW      = 35;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgIdxEnable     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxPumpRate   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxSpinner    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpeedThr   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxPumpFloor  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxPumpAssign = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgIdxOnDelay    = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxOffDelay   = 3'd7;

  typedef struct packed {
    logic        sprayer_enable;
    logic [13:0] pump_rate_centi;
    logic [10:0] spinner_pulse;
    logic [9:0]  speed_threshold;
    logic [6:0]  pump_floor_pct;
    logic        pump_assigned;
    logic [15:0] on_delay_ms;
    logic [15:0] off_delay_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    sprayer_enable:  1'b0,
    pump_rate_centi: 14'd1000,
    spinner_pulse:   11'd1300,
    speed_threshold: 10'd100,
    pump_floor_pct:  7'd0,
    pump_assigned:   1'b1,
    on_delay_ms:     16'd100,
    off_delay_ms:    16'd1000
  };

  typedef struct packed {
    logic               func;
    logic               run_request;
    logic [31:0]        time_ms;
    logic [13:0]        travel_speed;
    logic               test_mode;
    logic signed [15:0] ref_flow_gain;
    logic signed [15:0] measured_flow;
  } in_req_t;

  typedef struct packed {
    logic        pump_driven;
    logic [13:0] pump_position;
    logic [10:0] spinner_out;
    logic        spraying_now;
    logic        running_now;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic mul;
    logic err;
    logic scale;
    logic abs;
    logic div;
    logic fix;
    logic upd;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic loop;
  } dp_sts_t;

endpackage

FILE: sv/spfc_ctrl.sv
module spfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  output logic              out_load_o,
  input  spfc_pkg::dp_sts_t sts_i,
  output spfc_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDec  = 4'd1;
  localparam logic [3:0] StMul  = 4'd2;
  localparam logic [3:0] StErr  = 4'd3;
  localparam logic [3:0] StScl  = 4'd4;
  localparam logic [3:0] StAbs  = 4'd5;
  localparam logic [3:0] StDiv  = 4'd6;
  localparam logic [3:0] StFix  = 4'd7;
  localparam logic [3:0] StUpd  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  localparam logic [spfc_pkg::DivCntW-1:0] DivLast =
    spfc_pkg::DivCntW'(spfc_pkg::DivIters - 1);

  logic [3:0] state_q, state_d;
  logic [spfc_pkg::DivCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDec;
        end
      end
      StDec: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.loop ? StMul : StOut;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StErr;
      end
      StErr: begin
        cmd_o.err = 1'b1;
        state_d   = StScl;
      end
      StScl: begin
        cmd_o.scale = 1'b1;
        state_d     = StAbs;
      end
      StAbs: begin
        cmd_o.abs = 1'b1;
        cnt_d     = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = StFix;
        end
      end
      StFix: begin
        cmd_o.fix = 1'b1;
        state_d   = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o, out_load_o}))
    else $error("more than one datapath command at once");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.abs |=> cmd_o.div ##(spfc_pkg::DivIters) cmd_o.fix)
    else $error("divide did not run its full length");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_ready_o)
    else $error("request taken while busy");

endmodule

FILE: sv/spfc_datapath.sv
module spfc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spfc_pkg::cfg_t     cfg_i,
  input  spfc_pkg::in_req_t  in_req_i,
  input  spfc_pkg::dp_cmd_t  cmd_i,
  output spfc_pkg::dp_sts_t  sts_o,
  output spfc_pkg::out_rsp_t rsp_o
);

  // captured request
  spfc_pkg::in_req_t req_q;

  // flight state
  logic                       running_q, running_d;
  logic                       spraying_q, spraying_d;
  logic [spfc_pkg::PosW-1:0]  accum_q, accum_d;
  logic [31:0]                over_q, over_d;
  logic [31:0]                under_q, under_d;

  // loop arithmetic
  logic [13:0]                          speed_eff;
  logic signed [spfc_pkg::ProdW-1:0]    prod_q;
  logic signed [spfc_pkg::Flow100W-1:0] flow100_q;
  logic signed [spfc_pkg::ProdW-1:0]    err_q;
  logic signed [spfc_pkg::ScaledW-1:0]  scaled_q;
  logic [spfc_pkg::ScaledW-1:0]         scaled_neg;
  logic                                 neg_q;
  logic [spfc_pkg::DivW-1:0]            div_q;
  logic [spfc_pkg::RemW-1:0]            rem_q;
  logic                                 phase_q;
  logic [spfc_pkg::DivVW-1:0]           div_v;
  logic [spfc_pkg::RecipProdW-1:0]      recip_q;
  logic [spfc_pkg::DivChunkW-1:0]       q_chunk;
  logic [spfc_pkg::DivVW-1:0]           r_full;
  logic [spfc_pkg::QuotW-1:0]           quot;
  logic signed [spfc_pkg::DeltaW-1:0]   delta_q, delta_d;
  logic signed [spfc_pkg::DeltaW-1:0]   pos, pos_lo, lo_s, hi_s;
  logic [13:0]                          floor_int;

  logic        want, loop;
  logic [31:0] over_elapsed, under_elapsed;

  assign over_elapsed  = req_q.time_ms - over_q;
  assign under_elapsed = req_q.time_ms - under_q;

  // decision and state update
  always_comb begin
    running_d  = running_q;
    spraying_d = spraying_q;
    accum_d    = accum_q;
    over_d     = over_q;
    under_d    = under_q;
    want       = spraying_q;
    loop       = 1'b0;
    if (cmd_i.decide) begin
      if (req_q.func) begin
        if (req_q.run_request != running_q) begin
          running_d = req_q.run_request & cfg_i.sprayer_enable;
          if (!(req_q.run_request & cfg_i.sprayer_enable)) begin
            spraying_d = 1'b0;
            accum_d    = spfc_pkg::PosReset;
          end
        end
      end else if (!cfg_i.sprayer_enable || !running_q) begin
        if (running_q) begin
          running_d  = 1'b0;
          spraying_d = 1'b0;
          accum_d    = spfc_pkg::PosReset;
        end
      end else if (cfg_i.pump_assigned) begin
        if (req_q.travel_speed >= {4'b0, cfg_i.speed_threshold}) begin
          if (!spraying_q) begin
            if (over_q == '0) begin
              over_d = req_q.time_ms;
            end else if (over_elapsed > {16'b0, cfg_i.on_delay_ms}) begin
              want   = 1'b1;
              over_d = '0;
            end
          end
          under_d = '0;
        end else begin
          if (spraying_q) begin
            if (under_q == '0) begin
              under_d = req_q.time_ms;
            end else if (under_elapsed > {16'b0, cfg_i.off_delay_ms}) begin
              want    = 1'b0;
              under_d = '0;
            end
          end
          over_d = '0;
        end
        if (req_q.test_mode) begin
          want = 1'b1;
        end
        if (want) begin
          loop = 1'b1;
        end else begin
          spraying_d = 1'b0;
          accum_d    = spfc_pkg::PosReset;
        end
      end
    end
    if (cmd_i.upd) begin
      spraying_d = 1'b1;
      accum_d    = pos[spfc_pkg::PosW-1:0];
    end
  end

  assign sts_o.loop = loop;

  assign speed_eff = req_q.test_mode ? spfc_pkg::TestSpeed : req_q.travel_speed;

  // divide by 625, one 16-bit digit at a time: the first step multiplies
  // remainder:digit by the reciprocal, the second forms the new remainder
  assign div_v   = {rem_q, div_q[spfc_pkg::DivW-1 -: spfc_pkg::DivChunkW]};
  assign q_chunk = recip_q[spfc_pkg::RecipShift +: spfc_pkg::DivChunkW];
  assign r_full  = div_v - {{spfc_pkg::RemW{1'b0}}, q_chunk} *
                           spfc_pkg::DivVW'(spfc_pkg::DivConst);

  assign scaled_neg = -scaled_q;
  assign quot       = div_q[spfc_pkg::QuotW-1:0];

  // floor toward minus infinity on the sign-magnitude quotient
  always_comb begin
    if (neg_q) begin
      delta_d = -$signed({2'b0, quot} + {{(spfc_pkg::DeltaW-1){1'b0}}, (rem_q != '0)});
    end else begin
      delta_d = $signed({2'b0, quot});
    end
  end

  // new position, floor clamp first, then ceiling
  assign floor_int = 14'(cfg_i.pump_floor_pct) * 14'd100;
  assign lo_s = $signed({15'b0, floor_int, {spfc_pkg::PosFracBits{1'b0}}});
  assign hi_s = $signed({15'b0, spfc_pkg::PosMax});
  assign pos_lo = $signed({15'b0, accum_q}) + delta_q;

  always_comb begin
    pos = pos_lo;
    if (pos < lo_s) begin
      pos = lo_s;
    end
    if (pos > hi_s) begin
      pos = hi_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      spraying_q <= 1'b0;
      accum_q    <= spfc_pkg::PosReset;
      over_q     <= '0;
      under_q    <= '0;
    end else begin
      running_q  <= running_d;
      spraying_q <= spraying_d;
      accum_q    <= accum_d;
      over_q     <= over_d;
      under_q    <= under_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.mul) begin
      prod_q    <= spfc_pkg::ProdW'($signed({1'b0, speed_eff})) *
                   spfc_pkg::ProdW'(req_q.ref_flow_gain);
      flow100_q <= spfc_pkg::Flow100W'(req_q.measured_flow * 23'sd100);
    end
    if (cmd_i.err) begin
      err_q <= prod_q - {{(spfc_pkg::ProdW - spfc_pkg::Flow100W){flow100_q[22]}}, flow100_q};
    end
    if (cmd_i.scale) begin
      scaled_q <= spfc_pkg::ScaledW'(err_q) *
                  spfc_pkg::ScaledW'($signed({1'b0, cfg_i.pump_rate_centi}));
    end
    if (cmd_i.abs) begin
      neg_q   <= scaled_q[spfc_pkg::ScaledW-1];
      div_q   <= {{(spfc_pkg::DivW - spfc_pkg::MagW){1'b0}},
                  scaled_q[spfc_pkg::ScaledW-1] ? scaled_neg[spfc_pkg::MagW-1:0]
                                                : scaled_q[spfc_pkg::MagW-1:0]};
      rem_q   <= '0;
      phase_q <= 1'b0;
    end
    if (cmd_i.div) begin
      if (!phase_q) begin
        recip_q <= {{spfc_pkg::RecipW{1'b0}}, div_v} *
                   {{spfc_pkg::DivVW{1'b0}}, spfc_pkg::RecipConst};
      end else begin
        div_q <= {div_q[spfc_pkg::DivW-spfc_pkg::DivChunkW-1:0], q_chunk};
        rem_q <= r_full[spfc_pkg::RemW-1:0];
      end
      phase_q <= !phase_q;
    end
    if (cmd_i.fix) begin
      delta_q <= delta_d;
    end
  end

  assign rsp_o.pump_driven   = spraying_q;
  assign rsp_o.pump_position = accum_q[spfc_pkg::PosW-1:spfc_pkg::PosFracBits];
  assign rsp_o.spinner_out   = spraying_q ? cfg_i.spinner_pulse : '0;
  assign rsp_o.spraying_now  = spraying_q;
  assign rsp_o.running_now   = running_q;

  a_accum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_q <= spfc_pkg::PosMax)
    else $error("pump position above ceiling");

  a_spray_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spraying_q |-> running_q)
    else $error("spraying while not running");

  a_halt_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> (accum_q == spfc_pkg::PosReset) && !spraying_q)
    else $error("stop did not return pump to rest");

endmodule

FILE: sv/sprayer_pump_flow_controller.sv
// sprayer pump flow controller
// requests come in on in_valid_i/in_ready_o with an in_req_t payload: either a
// run command (func set) that sets the running flag to request AND enable, or an
// update tick carrying time, ground speed, test flag and two flowmeter values.
// each request gives exactly one result on out_valid_o/out_ready_i: the pump
// drive flag, pump position, spinner pulse and the spraying and running flags.
// configuration goes through cfg_we_i/cfg_index_i/cfg_wdata_i, one register per
// write; the user must see that it is only written while the block is idle,
// as the block itself does not enforce it. a run command or a tick that does
// not run the loop goes from the decision straight to the output; a tick that
// integrates the pump position runs one signed 15x16 multiply, the subtract,
// one 31x15 multiply, the magnitude, a divide by 625 done as three 16-bit
// digits, each a reciprocal multiply and then a remainder step, the floor
// correction and the clamp; the block takes one request at a time
// a finished result sits in the output register; the next request is taken
// while it waits, and the block only stalls before loading the next result
// reset restores the register defaults, clears running and spraying, disarms
// both timers and puts the pump back at 800
module sprayer_pump_flow_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  spfc_pkg::in_req_t                 in_req_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output spfc_pkg::out_rsp_t                out_rsp_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [spfc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [spfc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  spfc_pkg::cfg_t     cfg_q, cfg_d;
  spfc_pkg::dp_cmd_t  cmd;
  spfc_pkg::dp_sts_t  sts;
  spfc_pkg::out_rsp_t rsp;
  spfc_pkg::out_rsp_t out_rsp_q;
  logic               out_valid_q;
  logic               out_load;
  logic               out_free;

  // configuration registers, truncated to their field widths
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        spfc_pkg::CfgIdxEnable:     cfg_d.sprayer_enable  = cfg_wdata_i[0];
        spfc_pkg::CfgIdxPumpRate:   cfg_d.pump_rate_centi = cfg_wdata_i[13:0];
        spfc_pkg::CfgIdxSpinner:    cfg_d.spinner_pulse   = cfg_wdata_i[10:0];
        spfc_pkg::CfgIdxSpeedThr:   cfg_d.speed_threshold = cfg_wdata_i[9:0];
        spfc_pkg::CfgIdxPumpFloor:  cfg_d.pump_floor_pct  = cfg_wdata_i[6:0];
        spfc_pkg::CfgIdxPumpAssign: cfg_d.pump_assigned   = cfg_wdata_i[0];
        spfc_pkg::CfgIdxOnDelay:    cfg_d.on_delay_ms     = cfg_wdata_i;
        spfc_pkg::CfgIdxOffDelay:   cfg_d.off_delay_ms    = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= spfc_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  spfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spfc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .rsp_o    (rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.pump_position <= 14'd10000))
    else $error("result position out of range");

  a_spinner_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.pump_driven) |-> (out_rsp_o.spinner_out == '0))
    else $error("spinner driven while pump idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("pending result overwritten");

endmodule

FILE: sim/spfc_tb_pkg.sv
package spfc_tb_pkg;
  import spfc_pkg::*;

  // predicts the pump controller result for every accepted request and
  // checks the results in order
  class pump_scoreboard;
    cfg_t            regs;
    bit              running;
    bit              spraying;
    logic [PosW-1:0] pump_pos;
    logic [31:0]     over_since;
    logic [31:0]     under_since;
    out_rsp_t        expected_rsp_q[$];
    int unsigned     mismatches;
    int unsigned     results;

    function new();
      regs        = CfgReset;
      running     = 1'b0;
      spraying    = 1'b0;
      pump_pos    = PosReset;
      over_since  = '0;
      under_since = '0;
      mismatches  = 0;
      results     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgIdxEnable:     regs.sprayer_enable  = data[0];
        CfgIdxPumpRate:   regs.pump_rate_centi = data[13:0];
        CfgIdxSpinner:    regs.spinner_pulse   = data[10:0];
        CfgIdxSpeedThr:   regs.speed_threshold = data[9:0];
        CfgIdxPumpFloor:  regs.pump_floor_pct  = data[6:0];
        CfgIdxPumpAssign: regs.pump_assigned   = data[0];
        CfgIdxOnDelay:    regs.on_delay_ms     = data;
        CfgIdxOffDelay:   regs.off_delay_ms    = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_rsp_q.size();
    endfunction

    function void stop_pump();
      spraying = 1'b0;
      pump_pos = PosReset;
    endfunction

    function void set_running(bit req);
      if (req == running) return;
      running = req && regs.sprayer_enable;
      if (!running) stop_pump();
    endfunction

    function void note_request(in_req_t r);
      bit          want;
      longint      speed;
      longint      err;
      longint      num;
      longint      delta;
      longint      pos;
      longint      lo;
      logic [31:0] elapsed;
      out_rsp_t    rsp;
      if (r.func) begin
        set_running(r.run_request);
      end else if (!regs.sprayer_enable || !running) begin
        set_running(1'b0);
      end else if (regs.pump_assigned) begin
        want  = spraying;
        speed = longint'(r.travel_speed);
        if (speed >= longint'(regs.speed_threshold)) begin
          if (!spraying) begin
            elapsed = r.time_ms - over_since;
            if (over_since == '0) begin
              over_since = r.time_ms;
            end else if (elapsed > 32'(regs.on_delay_ms)) begin
              want       = 1'b1;
              over_since = '0;
            end
          end
          under_since = '0;
        end else begin
          if (spraying) begin
            elapsed = r.time_ms - under_since;
            if (under_since == '0) begin
              under_since = r.time_ms;
            end else if (elapsed > 32'(regs.off_delay_ms)) begin
              want        = 1'b0;
              under_since = '0;
            end
          end
          over_since = '0;
        end
        // test mode forces the loop and changes its speed, timers saw the real one
        if (r.test_mode) begin
          speed = longint'(TestSpeed);
          want  = 1'b1;
        end
        if (want) begin
          err = speed * longint'(r.ref_flow_gain) - 100 * longint'(r.measured_flow);
          num = err * longint'(regs.pump_rate_centi) * 16;
          // round toward minus infinity
          delta = (num >= 0) ? num / 10000 : -((-num + 9999) / 10000);
          pos   = longint'(pump_pos) + delta;
          lo    = longint'(regs.pump_floor_pct) * 100 * 256;
          if (pos < lo) pos = lo;
          if (pos > longint'(PosMax)) pos = longint'(PosMax);
          pump_pos = pos[PosW-1:0];
          spraying = 1'b1;
        end else begin
          stop_pump();
        end
      end
      rsp.pump_driven   = spraying;
      rsp.pump_position = pump_pos[PosW-1:PosFracBits];
      rsp.spinner_out   = spraying ? regs.spinner_pulse : '0;
      rsp.spraying_now  = spraying;
      rsp.running_now   = running;
      expected_rsp_q.push_back(rsp);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR result %0d %s: expected %0d, got %0d", results, name, exp_v, act_v);
      end
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want_rsp;
      results++;
      if (expected_rsp_q.size() == 0) begin
        check_field("results pending", 32'd0, 32'd1);
        return;
      end
      want_rsp = expected_rsp_q.pop_front();
      check_field("pump_driven", 32'(want_rsp.pump_driven), 32'(got.pump_driven));
      check_field("pump_position", 32'(want_rsp.pump_position), 32'(got.pump_position));
      check_field("spinner_out", 32'(want_rsp.spinner_out), 32'(got.spinner_out));
      check_field("spraying_now", 32'(want_rsp.spraying_now), 32'(got.spraying_now));
      check_field("running_now", 32'(want_rsp.running_now), 32'(got.running_now));
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
module tb_top;
  import spfc_pkg::*;
  import spfc_tb_pkg::*;

  // generous bound: every request at the slow loop latency, the longest
  // sender gap and the longest result stall, taken several times over
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPhases = 16;
  localparam int unsigned PhaseReqs  = 100;

  // result side stall patterns
  typedef enum int unsigned {
    RxAlways,
    RxRandom,
    RxPeriodic,
    RxBursty
  } rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_req_t             in_req_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_rsp_t            out_rsp_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  pump_scoreboard sb;
  cfg_t           cur_cfg;
  logic [31:0]    clock_ms;
  bit             fast_regime;
  int unsigned    cycle_cnt = 0;

  rx_mode_e    rx_mode   = RxAlways;
  int unsigned rx_left   = 0;
  int unsigned hold_left = 0;
  bit          hold_lvl  = 1'b0;

  sprayer_pump_flow_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check what is taken, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 400);
    end
    rx_left--;
    case (rx_mode)
      RxAlways:   out_ready_i <= 1'b1;
      RxRandom:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RxPeriodic: out_ready_i <= ((rx_left % 5) < 2);
      default: begin
        // long runs of ready and of stall, each of random length
        if (hold_left == 0) begin
          hold_lvl  = !hold_lvl;
          hold_left = $urandom_range(1, 20);
        end
        hold_left--;
        out_ready_i <= hold_lvl;
      end
    endcase
  end

  // update tick with the other fields as given, run_request is random
  function automatic in_req_t make_tick(logic [31:0] t, int spd, bit tm, int rf, int fl);
    in_req_t r;
    r.func          = 1'b0;
    r.run_request   = 1'($urandom_range(0, 1));
    r.time_ms       = t;
    r.travel_speed  = 14'(spd);
    r.test_mode     = tm;
    r.ref_flow_gain = 16'(rf);
    r.measured_flow = 16'(fl);
    return r;
  endfunction

  // run command, tick fields carry noise
  function automatic in_req_t make_run(bit req);
    in_req_t r;
    r = make_tick($urandom, $urandom_range(0, 10000), 1'($urandom_range(0, 1)),
                  $urandom, $urandom);
    r.func        = 1'b1;
    r.run_request = req;
    return r;
  endfunction

  // mostly realistic ticks: rising time, speed that dwells above or below
  // the threshold, flow near the reference; some fully random values, some run commands
  function automatic in_req_t next_item();
    int unsigned step_max;
    int          spd;
    int          rf;
    int          fl;
    int unsigned thr;
    thr = cur_cfg.speed_threshold;
    if ($urandom_range(0, 99) < 12) return make_run($urandom_range(0, 99) < 75);
    step_max = ((cur_cfg.on_delay_ms > cur_cfg.off_delay_ms) ?
                cur_cfg.on_delay_ms : cur_cfg.off_delay_ms) / 4 + 30;
    clock_ms = clock_ms + $urandom_range(0, step_max);
    if ($urandom_range(0, 99) < 2) clock_ms = $urandom;
    else if ($urandom_range(0, 99) < 1) clock_ms = '0;
    if ($urandom_range(0, 99) < 10) fast_regime = !fast_regime;
    if ($urandom_range(0, 99) < 5) spd = $urandom_range(0, 10000);
    else if (fast_regime || thr == 0) spd = $urandom_range(thr, 10000);
    else spd = $urandom_range(0, thr - 1);
    if ($urandom_range(0, 99) < 30) begin
      rf = $urandom;
      fl = $urandom;
    end else begin
      rf = int'($urandom_range(0, 400));
      fl = spd * rf / 100 + int'($urandom_range(0, 400)) - 200;
      if (fl > 32767) fl = 32767;
    end
    return make_tick(clock_ms, spd, $urandom_range(0, 99) < 6, rf, fl);
  endfunction

  // pick a register value, all low in phase 1, all high in phase 2
  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi, int phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (phase == 1 || (phase > 2 && roll < 20)) return lo;
    if (phase == 2 || (phase > 2 && roll < 35)) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic cfg_t random_cfg(int phase);
    cfg_t c;
    c.sprayer_enable  = (phase <= 2) || ($urandom_range(0, 99) < 90);
    c.pump_rate_centi = 14'(pick_value(0, 10000, phase));
    c.spinner_pulse   = 11'(pick_value(0, 2000, phase));
    c.speed_threshold = 10'(pick_value(0, 1000, phase));
    c.pump_floor_pct  = 7'(pick_value(0, 100, phase));
    c.pump_assigned   = (phase <= 2) || ($urandom_range(0, 99) < 85);
    c.on_delay_ms     = 16'(pick_value(0, (phase == 2 || $urandom_range(0, 9) == 0) ?
                                           65535 : 300, phase));
    c.off_delay_ms    = 16'(pick_value(0, (phase == 2 || $urandom_range(0, 9) == 0) ?
                                           65535 : 300, phase));
    return c;
  endfunction

  // call at a rising edge; returns at the edge where the request was taken
  task automatic send_req(in_req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  // lower valid and wait until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // only while idle: after reset or after drain
  task automatic program_regs(cfg_t c);
    write_reg(CfgIdxEnable,     CfgDataW'(c.sprayer_enable));
    write_reg(CfgIdxPumpRate,   CfgDataW'(c.pump_rate_centi));
    write_reg(CfgIdxSpinner,    CfgDataW'(c.spinner_pulse));
    write_reg(CfgIdxSpeedThr,   CfgDataW'(c.speed_threshold));
    write_reg(CfgIdxPumpFloor,  CfgDataW'(c.pump_floor_pct));
    write_reg(CfgIdxPumpAssign, CfgDataW'(c.pump_assigned));
    write_reg(CfgIdxOnDelay,    CfgDataW'(c.on_delay_ms));
    write_reg(CfgIdxOffDelay,   CfgDataW'(c.off_delay_ms));
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  initial begin
    cfg_t        c;
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    sb          = new();
    cur_cfg     = CfgReset;
    clock_ms    = 32'd1000;
    fast_regime = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: sprayer disabled
    send_req(make_tick(32'd50, 500, 1'b0, 16, 32));   // tick while not running
    send_req(make_run(1'b1));                         // run refused while disabled
    send_req(make_run(1'b0));                         // request unchanged
    drain();

    c                 = CfgReset;
    c.sprayer_enable  = 1'b1;
    c.spinner_pulse   = 11'd2000;
    c.on_delay_ms     = 16'd20;
    c.off_delay_ms    = 16'd30;
    program_regs(c);
    send_req(make_run(1'b1));
    send_req(make_run(1'b1));                                // request unchanged
    send_req(make_tick(32'd0, 10000, 1'b0, 0, 0));           // time zero leaves timer unarmed
    send_req(make_tick(32'd5, 200, 1'b0, 0, 0));             // over timer armed
    send_req(make_tick(32'd25, 200, 1'b0, 0, 0));            // elapsed equals on delay
    send_req(make_tick(32'd26, 200, 1'b0, 16, 32));          // spraying starts, zero error
    send_req(make_tick(32'd27, 10000, 1'b0, 32767, -32768)); // drive into the top clamp
    send_req(make_tick(32'd28, 200, 1'b0, -32768, 32767));   // drive into the floor
    send_req(make_tick(32'd29, 0, 1'b0, 16, -100));          // under timer armed
    send_req(make_tick(32'd59, 50, 1'b0, 16, 0));            // elapsed equals off delay
    send_req(make_tick(32'd60, 50, 1'b0, 16, 0));            // spraying stops
    send_req(make_tick(32'd61, 0, 1'b1, 100, 0));            // test mode forces the loop
    send_req(make_run(1'b0));                                // stop running
    send_req(make_tick(32'd62, 5000, 1'b0, 16, 0));          // tick while stopped
    drain();

    // floor above the top clamp, zero threshold and on delay, time wrap
    c.pump_rate_centi = 14'd10000;
    c.spinner_pulse   = 11'd0;
    c.speed_threshold = 10'd0;
    c.pump_floor_pct  = 7'd127;
    c.on_delay_ms     = 16'd0;
    c.off_delay_ms    = 16'd65535;
    program_regs(c);
    send_req(make_run(1'b1));
    send_req(make_tick(32'hFFFF_FFF0, 0, 1'b0, 0, 0));
    send_req(make_tick(32'h0000_0005, 0, 1'b0, 0, 0));       // wrapped elapsed time
    send_req(make_tick(32'h0000_0010, 300, 1'b0, -5, 7));
    drain();

    // disabled while running: the next tick clears running
    c.sprayer_enable = 1'b0;
    program_regs(c);
    send_req(make_tick(32'd20, 300, 1'b0, 0, 0));
    send_req(make_run(1'b1));
    drain();

    // pump output not assigned: ticks change nothing
    c.sprayer_enable = 1'b1;
    c.pump_assigned  = 1'b0;
    program_regs(c);
    send_req(make_run(1'b1));
    send_req(make_tick(32'd40, 900, 1'b1, 100, 0));
    drain();

    // random phases, each with its own register setting
    for (int phase = 0; phase < RandPhases; phase++) begin
      program_regs(random_cfg(phase));
      if (phase % 5 == 4) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
      // start most phases running
      send_req(make_run(1'b1));
      left = PhaseReqs;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        // every fourth phase runs the request side with no gaps
        gap   = (phase % 4 == 3) ? 0 : $urandom_range(0, 6);
        for (int b = 0; b < burst && left > 0; b++) begin
          send_req(next_item());
          left--;
        end
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      drain();
    end

    // settle: catch any stray result after the last one
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
